// ===== sv/rs485_modbus_half_duplex_link_top_macros.svh =====
// Assertion macros for the RS485 link controller.
`ifndef RS485_MODBUS_HALF_DUPLEX_LINK_TOP_MACROS_SVH
`define RS485_MODBUS_HALF_DUPLEX_LINK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RML_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define RML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RML_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/rml_pkg.sv =====
// Shared constants for the RS485 link controller.
package rml_pkg;

    localparam int BUFFER_BYTES_DEF = 128;
    localparam int TIME_BITS_DEF    = 32;

    localparam int MODE_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int READ_IDX_W  = 7;
    localparam int NOW_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [MODE_W-1:0] MODE_RX_BYTE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_BYTE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STEP      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RX_RESET  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 2'd1;

    localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [BYTE_W-1:0] FUNC_WRITE_MULTI  = 8'h10;
    localparam logic [BYTE_W-1:0] WRITE_MULTI_LEN   = 8'd8;
    localparam logic [BYTE_W-1:0] READ_HDR_LEN      = 8'd5;
    localparam int                MIN_RULE_BYTES    = 4;
    localparam logic [BYTE_W-1:0] TURNAROUND_RST    = 8'd1;
    localparam logic [BYTE_W-1:0] FRAME_GAP_RST     = 8'd1;

endpackage

// ===== sv/rml_in_if.sv =====
// Input item channel of the RS485 link controller.
interface rml_in_if;
    import rml_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [BYTE_W-1:0]     data_byte;
    logic                  byte_last;
    logic [READ_IDX_W-1:0] read_index;
    logic [NOW_W-1:0]      now_ms;
    logic                  tx_fifo_full;
    logic                  tx_line_done;

    modport source (output valid, mode, data_byte, byte_last, read_index, now_ms,
                    tx_fifo_full, tx_line_done, input ready);
    modport sink   (input valid, mode, data_byte, byte_last, read_index, now_ms,
                    tx_fifo_full, tx_line_done, output ready);
endinterface

// ===== sv/rml_out_if.sv =====
// Result item channel of the RS485 link controller.
interface rml_out_if;
    import rml_pkg::*;

    logic              valid;
    logic              ready;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              drive_enable;
    logic              busy_res;
    logic              frame_ready;
    logic [BYTE_W-1:0] rx_length;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, tx_valid, tx_byte, drive_enable, busy_res, frame_ready,
                    rx_length, read_data, input ready);
    modport sink   (input valid, tx_valid, tx_byte, drive_enable, busy_res, frame_ready,
                    rx_length, read_data, output ready);
endinterface

// ===== sv/rml_cfg_if.sv =====
// Configuration write channel of the RS485 link controller.
interface rml_cfg_if;
    import rml_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rml_ram.sv =====
// Generic single-port RAM with registered read and read enable.
module rml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/rs485_modbus_half_duplex_link_top.sv =====
// Top level of the half-duplex RS485 Modbus link controller.
//
// Usage: every input item on i_in is one event: a byte from the UART receiver,
// one byte of a message to send, a process step (millisecond poll), a buffer
// read, or a receive reset. Each accepted item yields exactly one result item
// on o_out with the UART write strobe and byte, the driver enable, the busy
// and frame-ready flags, the received length and the read byte.
// Registers turnaround_ms and frame_gap_ms are written through i_cfg, which
// is always ready; writes are expected only while the block is idle.
// Throughput is one item per clock cycle while the receiver takes results; the item
// is decoded against the control registers and touches the single-port
// frame buffer RAM once, and the RAM's registered read feeds the result.
// The result is held in an output register. When the receiver stalls, the
// register and the RAM read data hold, and i_in.ready drops until the
// waiting result is taken; a new item is accepted in the cycle it is.
// A synchronous active-low reset returns the link to idle, clears counts,
// flags and times, sets both registers to one and empties the output
// register. The buffer itself is not cleared: a buffer read of a byte not yet
// written returns whatever the RAM holds.
`include "rs485_modbus_half_duplex_link_top_macros.svh"
module rs485_modbus_half_duplex_link_top #(
    parameter int BUFFER_BYTES = rml_pkg::BUFFER_BYTES_DEF,
    parameter int TIME_BITS    = rml_pkg::TIME_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rml_in_if.sink  i_in,
    rml_cfg_if.sink i_cfg,
    rml_out_if.source o_out
);
    import rml_pkg::*;

    // Buffer address and count widths; a count must hold BUFFER_BYTES itself.
    localparam int AW    = $clog2(BUFFER_BYTES);
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUFFER_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOADING,
        ST_SET_TX,
        ST_TX_DELAY,
        ST_SENDING,
        ST_WAIT_DONE,
        ST_SET_RX,
        ST_RX_DELAY,
        ST_RECEIVING
    } t_link_state;

    // Control state.
    t_link_state      r_state, n_state;
    logic [CNT_W-1:0] r_rx_cnt, n_rx_cnt;
    logic [CNT_W-1:0] r_send_len, n_send_len;
    logic [CNT_W-1:0] r_send_pos, n_send_pos;
    logic [TIME_BITS-1:0] r_last_time, n_last_time;
    logic [TIME_BITS-1:0] r_delay_start, n_delay_start;
    logic             r_frame_done, n_frame_done;
    logic             r_driver_on, n_driver_on;
    logic [BYTE_W-1:0] r_turnaround;
    logic [BYTE_W-1:0] r_frame_gap;

    // Copies of buffer bytes one (function code) and two (byte count), kept
    // so the length rule needs no extra buffer read.
    logic [BYTE_W-1:0] r_func, n_func;
    logic [BYTE_W-1:0] r_byte_cnt, n_byte_cnt;

    // Output register.
    logic              r_out_valid;
    logic              r_o_tx_valid, n_o_tx_valid;
    logic              r_o_use_rd, n_o_use_rd;
    logic              r_o_drive;
    logic              r_o_busy;
    logic              r_o_frame;
    logic [BYTE_W-1:0] r_o_rx_len;

    // Buffer RAM port.
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_rdata;

    logic                 in_acc;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] delay_elapsed;
    logic [TIME_BITS-1:0] gap_elapsed;
    logic [BYTE_W-1:0]    expect_len;
    logic [CNT_W-1:0]     rx_base;
    logic [8:0]           read_idx_ext;
    logic [15:0]          rx_len_ext;

    rml_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_in.data_byte),
        .o_rdata (ram_rdata)
    );

    // A new item enters whenever the output register is free or being emptied.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign now           = i_in.now_ms[TIME_BITS-1:0];
    assign delay_elapsed = now - r_delay_start;
    assign gap_elapsed   = now - r_last_time;
    assign read_idx_ext  = {2'b00, i_in.read_index};

    // Expected Modbus frame length; zero means no length rule applies, which
    // also covers a read response whose length sum wraps to zero.
    always_comb begin
        if (r_func == FUNC_READ_HOLDING) begin
            expect_len = READ_HDR_LEN + r_byte_cnt;
        end else if (r_func == FUNC_WRITE_MULTI) begin
            expect_len = WRITE_MULTI_LEN;
        end else begin
            expect_len = '0;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_rx_cnt      = r_rx_cnt;
        n_send_len    = r_send_len;
        n_send_pos    = r_send_pos;
        n_last_time   = r_last_time;
        n_delay_start = r_delay_start;
        n_frame_done  = r_frame_done;
        n_driver_on   = r_driver_on;
        n_func        = r_func;
        n_byte_cnt    = r_byte_cnt;
        n_o_tx_valid  = 1'b0;
        n_o_use_rd    = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_addr      = '0;
        rx_base       = r_rx_cnt;

        if (in_acc) begin
            case (i_in.mode)
                MODE_RX_BYTE: begin
                    if (r_state == ST_IDLE || r_state == ST_RECEIVING) begin
                        // A byte arriving while idle opens a fresh frame.
                        if (r_state == ST_IDLE) begin
                            rx_base      = '0;
                            n_rx_cnt     = '0;
                            n_frame_done = 1'b0;
                            n_state      = ST_RECEIVING;
                        end
                        if (rx_base < BUF_CNT) begin
                            ram_we      = 1'b1;
                            ram_addr    = rx_base[AW-1:0];
                            n_rx_cnt    = rx_base + 1'b1;
                            n_last_time = now;
                            if (rx_base == CNT_W'(1)) begin
                                n_func = i_in.data_byte;
                            end
                            if (rx_base == CNT_W'(2)) begin
                                n_byte_cnt = i_in.data_byte;
                            end
                        end
                    end
                end
                MODE_LOAD_BYTE: begin
                    if (r_state == ST_IDLE) begin
                        // The first send byte takes over the buffer.
                        n_rx_cnt     = '0;
                        n_frame_done = 1'b0;
                        ram_we       = 1'b1;
                        ram_addr     = '0;
                        n_send_len   = CNT_W'(1);
                        n_send_pos   = '0;
                        n_state      = i_in.byte_last ? ST_SET_TX : ST_LOADING;
                    end else if (r_state == ST_LOADING) begin
                        if (r_send_len < BUF_CNT) begin
                            ram_we     = 1'b1;
                            ram_addr   = r_send_len[AW-1:0];
                            n_send_len = r_send_len + 1'b1;
                            if (r_send_len == CNT_W'(1)) begin
                                n_func = i_in.data_byte;
                            end
                            if (r_send_len == CNT_W'(2)) begin
                                n_byte_cnt = i_in.data_byte;
                            end
                        end
                        if (i_in.byte_last) begin
                            n_state = ST_SET_TX;
                        end
                    end
                end
                MODE_STEP: begin
                    case (r_state)
                        ST_SET_TX: begin
                            n_driver_on   = 1'b1;
                            n_delay_start = now;
                            n_state       = ST_TX_DELAY;
                        end
                        ST_TX_DELAY: begin
                            if (32'(delay_elapsed) >= 32'(r_turnaround)) begin
                                n_state = ST_SENDING;
                            end
                        end
                        ST_SENDING: begin
                            if (r_send_pos < r_send_len) begin
                                if (!i_in.tx_fifo_full) begin
                                    ram_re       = 1'b1;
                                    ram_addr     = r_send_pos[AW-1:0];
                                    n_o_tx_valid = 1'b1;
                                    n_send_pos   = r_send_pos + 1'b1;
                                end
                            end else begin
                                n_state = ST_WAIT_DONE;
                            end
                        end
                        ST_WAIT_DONE: begin
                            if (i_in.tx_line_done) begin
                                n_state = ST_SET_RX;
                            end
                        end
                        ST_SET_RX: begin
                            n_driver_on   = 1'b0;
                            n_delay_start = now;
                            n_state       = ST_RX_DELAY;
                        end
                        ST_RX_DELAY: begin
                            if (32'(delay_elapsed) >= 32'(r_turnaround)) begin
                                n_state = ST_IDLE;
                            end
                        end
                        ST_RECEIVING: begin
                            // Frame ends on the length rule or on a long gap.
                            if ((16'(r_rx_cnt) >= 16'(MIN_RULE_BYTES)) &&
                                (expect_len != '0) &&
                                (16'(r_rx_cnt) >= 16'(expect_len))) begin
                                n_frame_done = 1'b1;
                                n_state      = ST_IDLE;
                            end
                            if ((r_rx_cnt != '0) &&
                                (32'(gap_elapsed) > 32'(r_frame_gap))) begin
                                n_frame_done = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                MODE_READ: begin
                    if (read_idx_ext < 9'(BUFFER_BYTES)) begin
                        ram_re     = 1'b1;
                        ram_addr   = read_idx_ext[AW-1:0];
                        n_o_use_rd = 1'b1;
                    end
                end
                MODE_RX_RESET: begin
                    n_state      = ST_IDLE;
                    n_rx_cnt     = '0;
                    n_frame_done = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign rx_len_ext = 16'(n_rx_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rx_cnt      <= '0;
            r_send_len    <= '0;
            r_send_pos    <= '0;
            r_last_time   <= '0;
            r_delay_start <= '0;
            r_frame_done  <= 1'b0;
            r_driver_on   <= 1'b0;
            r_turnaround  <= TURNAROUND_RST;
            r_frame_gap   <= FRAME_GAP_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_rx_cnt      <= n_rx_cnt;
            r_send_len    <= n_send_len;
            r_send_pos    <= n_send_pos;
            r_last_time   <= n_last_time;
            r_delay_start <= n_delay_start;
            r_frame_done  <= n_frame_done;
            r_driver_on   <= n_driver_on;
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_TURNAROUND) begin
                    r_turnaround <= i_cfg.data;
                end else if (i_cfg.index == CFG_FRAME_GAP) begin
                    r_frame_gap <= i_cfg.data;
                end
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        r_func     <= n_func;
        r_byte_cnt <= n_byte_cnt;
        if (in_acc) begin
            r_o_tx_valid <= n_o_tx_valid;
            r_o_use_rd   <= n_o_use_rd;
            r_o_drive    <= n_driver_on;
            r_o_busy     <= (n_state != ST_IDLE) || n_frame_done;
            r_o_frame    <= n_frame_done;
            r_o_rx_len   <= rx_len_ext[BYTE_W-1:0];
        end
    end

    // The RAM read register only moves with an accepted read, so it holds
    // together with the output register while the receiver stalls.
    assign o_out.valid        = r_out_valid;
    assign o_out.tx_valid     = r_o_tx_valid;
    assign o_out.tx_byte      = r_o_tx_valid ? ram_rdata : '0;
    assign o_out.drive_enable = r_o_drive;
    assign o_out.busy_res     = r_o_busy;
    assign o_out.frame_ready  = r_o_frame;
    assign o_out.rx_length    = r_o_rx_len;
    assign o_out.read_data    = r_o_use_rd ? ram_rdata : '0;

    // Every accepted item leaves a result waiting in the next cycle.
    `RML_ASSERT_NEXT(a_item_gives_result, i_clk, i_rst_n, in_acc, r_out_valid, "item lost")
    // The driver is switched on only from the set-transmit step.
    `RML_ASSERT_SAME(a_drive_from_set_tx, i_clk, i_rst_n, $rose(r_driver_on),
                     $past(r_state) == ST_SET_TX, "driver switched on outside set-transmit")
    // Sending never runs past the loaded message.
    `RML_ASSERT_SAME(a_send_in_range, i_clk, i_rst_n, 1'b1,
                     r_send_pos <= r_send_len && r_send_len <= BUF_CNT, "send position overrun")
    // A UART write happens only from a send step.
    `RML_ASSERT_SAME(a_tx_from_sending, i_clk, i_rst_n, in_acc && n_o_tx_valid,
                     r_state == ST_SENDING && i_in.mode == MODE_STEP, "UART write outside send")
endmodule
